FILE: sv/barf_pkg.sv
`default_nettype none

package barf_pkg;

  localparam int LEVEL_BITS  = 16;
  localparam int WIN_BITS    = 4;
  localparam int SPA_BITS    = 8;
  localparam int SHIFT_BITS  = 3;
  localparam int CFG_BITS    = 8;
  localparam int INDEX_BITS  = 2;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR    = 2;

  localparam logic [WIN_BITS-1:0]   WINDOW_SIZE_RESET = 4'd5;
  localparam logic [SPA_BITS-1:0]   SPA_RESET         = 8'd8;
  localparam logic [SHIFT_BITS-1:0] SHIFT_RESET       = 3'd3;

  typedef enum logic [INDEX_BITS-1:0] {
    REG_WINDOW_SIZE         = 2'd0,
    REG_SAMPLES_PER_AVERAGE = 2'd1,
    REG_AVERAGE_SHIFT       = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [WIN_BITS-1:0]   window_size;
    logic [SPA_BITS-1:0]   samples_per_average;
    logic [SHIFT_BITS-1:0] average_shift;
  } cfg_t;

  // one block average handed from the accumulator to the queue
  typedef struct packed {
    logic                  valid;
    logic [LEVEL_BITS-1:0] avg;
  } avg_xfer_t;

endpackage

`default_nettype wire

FILE: sv/barf_front.sv
`default_nettype none

module barf_front
  import barf_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cfg_t                   cfg,
  input  wire logic                   accept,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  output avg_xfer_t                   push
);

  localparam int SUM_BITS = SAMPLE_BITS + SPA_BITS;

  logic [SUM_BITS-1:0] block_sum;
  logic [SPA_BITS-1:0] samples_in_block;
  logic [SUM_BITS-1:0] block_sum_next;
  logic [SPA_BITS-1:0] samples_in_block_next;
  logic [SPA_BITS-1:0] spa;
  logic [SUM_BITS-1:0] shifted;
  logic                closing;

  always_comb begin
    spa = (cfg.samples_per_average == '0) ? SPA_BITS'(1) : cfg.samples_per_average;
    block_sum_next = block_sum + SUM_BITS'(sample);
    samples_in_block_next = samples_in_block + SPA_BITS'(1);
    closing = (samples_in_block_next >= spa);
    shifted = block_sum_next >> cfg.average_shift;
    push.valid = accept && closing;
    // saturate the block average at full scale
    if (shifted > SUM_BITS'(65535)) begin
      push.avg = '1;
    end else begin
      push.avg = shifted[LEVEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_sum        <= '0;
      samples_in_block <= '0;
    end else if (accept) begin
      if (closing) begin
        block_sum        <= '0;
        samples_in_block <= '0;
      end else begin
        block_sum        <= block_sum_next;
        samples_in_block <= samples_in_block_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/barf_fifo.sv
`default_nettype none

module barf_fifo
  import barf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire avg_xfer_t             push,
  output logic                       full,
  input  wire logic                  pop,
  output avg_xfer_t                  head
);

  logic [LEVEL_BITS-1:0] mem [FIFO_DEPTH];
  logic [FIFO_PTR-1:0]   wr_ptr;
  logic [FIFO_PTR-1:0]   rd_ptr;
  logic [FIFO_PTR:0]     fill;
  logic                  do_pop;

  always_comb begin
    full       = (fill == (FIFO_PTR + 1)'(FIFO_DEPTH));
    head.valid = (fill != '0);
    head.avg   = mem[rd_ptr];
    do_pop     = pop && head.valid;
  end

  always_ff @(posedge clk) begin
    if (push.valid && !full) begin
      mem[wr_ptr] <= push.avg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push.valid && !full) begin
        wr_ptr <= wr_ptr + FIFO_PTR'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR'(1);
      end
      case ({push.valid && !full, do_pop})
        2'b10:   fill <= fill + (FIFO_PTR + 1)'(1);
        2'b01:   fill <= fill - (FIFO_PTR + 1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/barf_back.sv
`default_nettype none

module barf_back
  import barf_pkg::*;
#(
  parameter int MAX_WINDOW = 9
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cfg_t                  cfg,
  input  wire avg_xfer_t             head,
  output logic                       pop,
  output logic                       out_valid,
  output logic [LEVEL_BITS-1:0]      out_level,
  input  wire logic                  out_ready
);

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int IW = $clog2(MAX_WINDOW);

  logic [LEVEL_BITS-1:0] win      [MAX_WINDOW];
  logic [LEVEL_BITS-1:0] win_next [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] gt;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [CW-1:0]         n;
  logic [CW-1:0]         rank_raw;
  logic [CW-1:0]         rank;
  logic                  emit;
  logic [LEVEL_BITS-1:0] picked;

  always_comb begin
    // clamp the configured window into 2..MAX_WINDOW
    if (cfg.window_size < WIN_BITS'(2)) begin
      n = CW'(2);
    end else if ({1'b0, cfg.window_size} > 5'(MAX_WINDOW)) begin
      n = CW'(MAX_WINDOW);
    end else begin
      n = CW'(cfg.window_size);
    end

    for (int i = 0; i < MAX_WINDOW; i++) begin
      gt[i] = (CW'(i) < count) && (win[i] > head.avg);
    end

    // equal values stay in arrival order: the new one goes after them
    win_next[0] = ((count != '0) && !gt[0]) ? win[0] : head.avg;
    for (int i = 1; i < MAX_WINDOW; i++) begin
      if ((CW'(i) < count) && !gt[i]) begin
        win_next[i] = win[i];
      end else if (gt[i-1]) begin
        win_next[i] = win[i-1];
      end else begin
        win_next[i] = head.avg;
      end
    end

    count_next = count + CW'(1);
    emit       = (count_next >= n);
    rank_raw   = (n >> 2) + CW'(1);
    rank       = (rank_raw >= count_next) ? count_next - CW'(1) : rank_raw;
    picked     = win_next[IW'(rank)];

    // hold the queue only when a result is due and the output slot is stuck
    pop = head.valid && !(emit && out_valid && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
        win[i] <= win_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_level <= picked;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        count <= emit ? '0 : count_next;
      end
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/block_average_rank_filter_core.sv
// Block-average rank filter.
// Slave stream s_*: one converter sample per transfer in s_tdata. The samples
// are summed in blocks of samples_per_average (0 counts as 1), each sum is
// shifted right by average_shift and saturated to 16 bits, and the block
// averages are kept in an ascending sorted window. After window_size averages
// (clamped to 2..MAX_WINDOW) the entry at rank (window_size >> 2) + 1 leaves
// on the master stream m_* and a new window starts. Registers are written
// through cfg_we / cfg_index / cfg_data, only while the block is idle; the
// user is bound to this, the block does not enforce it. Throughput: one
// sample per cycle while s_tready is high. The accumulator feeds a four-entry
// queue of averages and the window takes one average per cycle from it. The
// closing average is written into the queue, popped into the window, and the
// picked entry is registered into m_tdata and m_tvalid; averages queued ahead
// of it can delay it. When m_tready is low the result is held in the output
// register; further averages still enter the window until one would produce a
// result, then the queue fills and s_tready drops. Reset (rst, synchronous)
// empties the sums, the queue and the window and restores window_size 5,
// samples_per_average 8, average_shift 3.
`default_nettype none

module block_average_rank_filter_core
  import barf_pkg::*;
#(
  parameter int MAX_WINDOW  = 9,
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [((SAMPLE_BITS + 7) / 8)*8-1:0] s_tdata,   // sample
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [LEVEL_BITS-1:0]                     m_tdata,   // level
  input  wire logic                                 cfg_we,
  input  wire logic [INDEX_BITS-1:0]                cfg_index,
  input  wire logic [CFG_BITS-1:0]                  cfg_data
);

  cfg_t      cfg;
  avg_xfer_t push;
  avg_xfer_t head;
  logic      full;
  logic      pop;
  logic      accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_size         <= WINDOW_SIZE_RESET;
      cfg.samples_per_average <= SPA_RESET;
      cfg.average_shift       <= SHIFT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_SIZE:         cfg.window_size         <= cfg_data[WIN_BITS-1:0];
        REG_SAMPLES_PER_AVERAGE: cfg.samples_per_average <= cfg_data[SPA_BITS-1:0];
        REG_AVERAGE_SHIFT:       cfg.average_shift       <= cfg_data[SHIFT_BITS-1:0];
        default:                 cfg                     <= cfg;
      endcase
    end
  end

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  barf_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .sample (s_tdata[SAMPLE_BITS-1:0]),
    .push   (push)
  );

  barf_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .pop  (pop),
    .head (head)
  );

  barf_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_level (m_tdata),
    .out_ready (m_tready)
  );

endmodule

`default_nettype wire

FILE: sv/barf_checker.sv
`default_nettype none

module barf_checker
  import barf_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [LEVEL_BITS-1:0] m_tdata
);

  // reset empties the queue and the output slot
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("output valid or input stalled after reset");

  // a result needs a sample transfer, the queue and the window first
  a_no_early_result: assert property (@(posedge clk) rst ##1 !rst |=> !m_tvalid)
    else $error("result appeared too soon after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

endmodule

bind block_average_rank_filter_core barf_checker u_barf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import barf_pkg::*;

  localparam int MAX_WIN     = 9;
  localparam int SAMPLE_BITS = 10;
  localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [TDATA_BITS-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [LEVEL_BITS-1:0]  m_tdata;
  logic                   cfg_we = 1'b0;
  logic [INDEX_BITS-1:0]  cfg_index = '0;
  logic [CFG_BITS-1:0]    cfg_data = '0;

  block_average_rank_filter_core #(
    .MAX_WINDOW (MAX_WIN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // sample
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // level
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor copy of the registers and the filter state
  logic [WIN_BITS-1:0]   win_cfg   = WINDOW_SIZE_RESET;
  logic [SPA_BITS-1:0]   spa_cfg   = SPA_RESET;
  logic [SHIFT_BITS-1:0] shift_cfg = SHIFT_RESET;
  logic [17:0]           acc_sum   = '0;
  logic [7:0]            acc_count = '0;
  int                    win_count = 0;
  logic [15:0]           win_vals [MAX_WIN];

  logic [TDATA_BITS-1:0] sample_queue [$];
  logic [LEVEL_BITS-1:0] expected_levels [$];
  logic [LEVEL_BITS-1:0] want_level;
  logic                  sample_taken = 1'b0;
  logic                  no_gaps = 1'b0;
  int                    errors = 0;
  int                    samples_in = 0;
  int                    levels_out = 0;
  int                    saturated = 0;
  int                    reg_writes = 0;

  task automatic flag_mismatch(input string msg);
    $display("tb: %s", msg);
    errors++;
  endtask

  function automatic logic [TDATA_BITS-1:0] rand_sample();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return TDATA_BITS'(10'h3FF);
    return TDATA_BITS'($urandom_range(0, 1023));
  endfunction

  task automatic predict_sample(input logic [SAMPLE_BITS-1:0] smp);
    logic [SPA_BITS-1:0] spa;
    logic [17:0]         shifted;
    logic [15:0]         avg;
    int                  cnt, pos, k, n, rank;
    spa = (spa_cfg == '0) ? SPA_BITS'(1) : spa_cfg;
    acc_sum   = acc_sum + 18'(smp);
    acc_count = acc_count + 8'd1;
    if (acc_count < spa) return;

    shifted = acc_sum >> shift_cfg;
    if (shifted > 18'd65535) begin
      avg = 16'hFFFF;
      saturated++;
    end else begin
      avg = shifted[15:0];
    end
    acc_sum   = '0;
    acc_count = '0;

    // insert after every entry not greater, so equal values keep arrival order
    cnt = (win_count >= MAX_WIN) ? MAX_WIN - 1 : win_count;
    pos = 0;
    while (pos < cnt && win_vals[pos] <= avg) pos++;
    for (k = cnt; k > pos; k--) win_vals[k] = win_vals[k-1];
    win_vals[pos] = avg;
    win_count = cnt + 1;

    n = int'(win_cfg);
    if (n < 2) n = 2;
    if (n > MAX_WIN) n = MAX_WIN;
    if (win_count < n) return;
    rank = (n >> 2) + 1;
    if (rank >= win_count) rank = win_count - 1;
    expected_levels.push_back(win_vals[rank]);
    win_count = 0;
  endtask

  // write one register while the block is idle and mirror it in the predictor
  task automatic write_reg(input reg_index_t idx, input logic [CFG_BITS-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_WINDOW_SIZE:         win_cfg   = val[WIN_BITS-1:0];
      REG_SAMPLES_PER_AVERAGE: spa_cfg   = val[SPA_BITS-1:0];
      REG_AVERAGE_SHIFT:       shift_cfg = val[SHIFT_BITS-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every sample is in and every level out, then let the queue drain
  task automatic settle_idle();
    int waited;
    waited = 0;
    while (sample_queue.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_levels.size() != 0 && waited < 500) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
  endtask

  always @(negedge clk) begin
    m_tready <= no_gaps || ($urandom_range(99) >= 7);
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || sample_taken) begin
      if (sample_queue.size() != 0 && (no_gaps || $urandom_range(99) >= 7)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= sample_queue.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      sample_taken = 1'b0;
    end else begin
      sample_taken = s_tvalid && s_tready;
      if (sample_taken) begin
        samples_in++;
        predict_sample(s_tdata[SAMPLE_BITS-1:0]);
      end
      if (m_tvalid && m_tready) begin
        levels_out++;
        if (expected_levels.size() == 0) begin
          flag_mismatch($sformatf("level %0d with none expected", m_tdata));
        end else begin
          want_level = expected_levels.pop_front();
          if (m_tdata !== want_level)
            flag_mismatch($sformatf("level: got %0d, expected %0d", m_tdata, want_level));
        end
      end
    end
  end

  initial begin
    int phase, len, random_items;
    phase = 0;
    random_items = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // reset register values: window 5, 8 samples per average, shift 3
    repeat (40) sample_queue.push_back(rand_sample());
    settle_idle();

    // each sample is an average, window of two
    write_reg(REG_WINDOW_SIZE, 8'd2);
    write_reg(REG_SAMPLES_PER_AVERAGE, 8'd1);
    write_reg(REG_AVERAGE_SHIFT, 8'd0);
    sample_queue.push_back(16'h0000);
    sample_queue.push_back(16'h03FF);
    sample_queue.push_back(16'h03FF);
    sample_queue.push_back(16'h0000);
    // bits above the sample field must be ignored
    sample_queue.push_back(16'hFC00);
    sample_queue.push_back(16'hFFFF);
    settle_idle();

    // window below two and zero samples per average, largest shift
    write_reg(REG_WINDOW_SIZE, 8'd0);
    write_reg(REG_SAMPLES_PER_AVERAGE, 8'd0);
    write_reg(REG_AVERAGE_SHIFT, 8'd7);
    sample_queue.push_back(16'h03FF);
    sample_queue.push_back(16'd500);
    settle_idle();

    // window above the maximum, equal values included
    write_reg(REG_WINDOW_SIZE, 8'd15);
    write_reg(REG_SAMPLES_PER_AVERAGE, 8'd1);
    write_reg(REG_AVERAGE_SHIFT, 8'd0);
    foreach (win_vals[i]) sample_queue.push_back((i % 3 == 0) ? 16'd77 : 16'(900 - 100 * i));
    settle_idle();

    write_reg(REG_WINDOW_SIZE, 8'd1);
    write_reg(REG_SAMPLES_PER_AVERAGE, 8'd2);
    write_reg(REG_AVERAGE_SHIFT, 8'd1);
    sample_queue.push_back(16'h03FF);
    sample_queue.push_back(16'h0001);
    sample_queue.push_back(16'h0200);
    sample_queue.push_back(16'h0155);
    settle_idle();

    // longest block at no shift: the sum exceeds 16 bits and the average saturates
    write_reg(REG_WINDOW_SIZE, 8'd9);
    write_reg(REG_SAMPLES_PER_AVERAGE, 8'd255);
    write_reg(REG_AVERAGE_SHIFT, 8'd0);
    repeat (255) sample_queue.push_back(TDATA_BITS'($urandom_range(512, 1023)));
    settle_idle();

    // random phases; registers change with a window part filled
    while (random_items < 280) begin
      phase++;
      no_gaps = (phase >= 4 && phase < 8);
      if ($urandom_range(3) != 0)
        write_reg(REG_WINDOW_SIZE, ($urandom_range(9) < 7) ? CFG_BITS'($urandom_range(2, 9))
                                                         : CFG_BITS'($urandom_range(0, 15)));
      if ($urandom_range(3) != 0) begin
        len = $urandom_range(99);
        write_reg(REG_SAMPLES_PER_AVERAGE,
                  (len < 60) ? CFG_BITS'($urandom_range(1, 4)) :
                  (len < 90) ? CFG_BITS'($urandom_range(5, 16)) :
                  (len < 95) ? CFG_BITS'(0) : CFG_BITS'($urandom_range(17, 255)));
      end
      if ($urandom_range(2) != 0)
        write_reg(REG_AVERAGE_SHIFT, CFG_BITS'($urandom_range(0, 7)));
      len = $urandom_range(8, 48);
      repeat (len) sample_queue.push_back(rand_sample());
      random_items += len;
      settle_idle();
    end
    no_gaps = 1'b0;

    settle_idle();
    if (expected_levels.size() != 0)
      flag_mismatch($sformatf("%0d levels never arrived", expected_levels.size()));
    $display("tb: %0d samples, %0d levels checked over %0d register writes and %0d phases",
             samples_in, levels_out, reg_writes, phase);
    $display("tb: %0d saturated averages, window sizes 0 to 15, block lengths 0 to 255",
             saturated);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
